@@ hdl/mltg_pkg.sv @@
`default_nettype none

package mltg_pkg;

  // Channel count of the state arrays. Only channels 0 to 7 show up in the masks.
  localparam int NUM_CHANNELS = 8;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int CHAN_W       = 3;
  localparam int TIME_W       = 32;
  localparam int MASK_W       = 8;
  localparam int MASK_IDX_W   = 3;
  localparam int EXCL_W       = 4;
  localparam logic [EXCL_W-1:0] EXCL_NONE = 4'd8;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_EXCLUDED = 1'b0;

  typedef enum logic [1:0] {
    CMD_SCAN       = 2'd0,
    CMD_FEED       = 2'd1,
    CMD_INIT       = 2'd2,
    CMD_ENABLE_ALL = 2'd3
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t              command;
    logic [CHAN_W-1:0]   channel;
    logic [TIME_W-1:0]   time_now;
    logic [TIME_W-1:0]   start_timeout;
    logic [TIME_W-1:0]   run_timeout;
    logic                close_en;
    logic [TIME_W-1:0]   close_delay;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] error_mask;
    logic [MASK_W-1:0] close_mask;
    logic [MASK_W-1:0] healthy_mask;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic                load_item;
    logic                apply;
    logic                clear_masks;
    logic                scan_issue;
    logic [CH_IDX_W-1:0] scan_idx;
    logic                load_out;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e_t command;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/mltg_ctrl.sv @@
`default_nettype none

module mltg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire mltg_pkg::dp_status_t status,
  output mltg_pkg::dp_cmd_t         cmd
);

  localparam logic [mltg_pkg::CH_IDX_W-1:0] LAST_CH =
    mltg_pkg::CH_IDX_W'(mltg_pkg::NUM_CHANNELS - 1);

  mltg_pkg::ctrl_state_t state_r, state_nxt;
  logic [mltg_pkg::CH_IDX_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mltg_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    in_ready        = (state_r == mltg_pkg::ST_IDLE);
    cmd             = '0;
    cmd.load_item   = in_valid && in_ready;
    cmd.scan_idx    = cnt_r;

    case (state_r)
      mltg_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mltg_pkg::ST_DISPATCH;
      end
      mltg_pkg::ST_DISPATCH: begin
        cmd.clear_masks = 1'b1;
        if (status.command == mltg_pkg::CMD_SCAN) begin
          cnt_nxt   = '0;
          state_nxt = mltg_pkg::ST_SCAN;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = mltg_pkg::ST_RESP;
        end
      end
      mltg_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (cnt_r == LAST_CH) begin
          state_nxt = mltg_pkg::ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + mltg_pkg::CH_IDX_W'(1);
        end
      end
      mltg_pkg::ST_DRAIN: begin
        // The last channel is still in the compare stage.
        state_nxt = mltg_pkg::ST_RESP;
      end
      mltg_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = mltg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mltg_pkg::ST_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/mltg_dp.sv @@
`default_nettype none

module mltg_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mltg_pkg::in_item_t            in_data,
  input  wire logic [mltg_pkg::EXCL_W-1:0]   excluded_channel,
  input  wire mltg_pkg::dp_cmd_t             cmd,
  output mltg_pkg::dp_status_t               status,
  output mltg_pkg::out_item_t                out_data
);

  localparam int NCH = mltg_pkg::NUM_CHANNELS;
  localparam int TW  = mltg_pkg::TIME_W;
  localparam int IW  = mltg_pkg::CH_IDX_W;

  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_START,
    CHK_RUN
  } chk_e_t;

  mltg_pkg::in_item_t item_r;

  logic [NCH-1:0] running_r;
  logic [NCH-1:0] starting_r;
  logic [NCH-1:0] healthy_r;
  logic [NCH-1:0] close_ok_r;
  logic [TW-1:0]  last_r      [NCH];
  logic [TW-1:0]  start_lim_r [NCH];
  logic [TW-1:0]  run_lim_r   [NCH];
  logic [TW-1:0]  close_lim_r [NCH];

  // Read stage.
  logic           sa_valid_r;
  logic [IW-1:0]  sa_idx_r;
  chk_e_t         sa_mode_r, sa_mode_nxt;
  logic [TW-1:0]  sa_elapsed_r, sa_elapsed_nxt;
  logic [TW-1:0]  sa_limit_r, sa_limit_nxt;
  logic [TW:0]    sa_bound_r, sa_bound_nxt;
  logic           sa_close_r;

  // Compare stage.
  logic                          timed_out;
  logic                          past_close;
  logic                          hit_err;
  logic                          hit_cls;
  logic                          clr_start;
  logic                          clr_run;
  logic [31:0]                   sb_idx_ext;
  logic                          sb_in_mask;
  logic [mltg_pkg::MASK_IDX_W-1:0] sb_bit;

  logic [mltg_pkg::MASK_W-1:0] err_r;
  logic [mltg_pkg::MASK_W-1:0] cls_r;
  logic [mltg_pkg::MASK_W-1:0] healthy_mask;
  mltg_pkg::out_item_t         out_r;

  logic [31:0]   ch_ext;
  logic          ch_ok;
  logic [IW-1:0] ch_idx;
  logic          not_excl;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
  end

  assign status.command = item_r.command;

  assign ch_ext   = 32'(item_r.channel);
  assign ch_ok    = (ch_ext < NCH);
  assign ch_idx   = ch_ext[IW-1:0];
  assign not_excl = ({1'b0, item_r.channel} != excluded_channel);

  always_comb begin
    sa_elapsed_nxt = item_r.time_now - last_r[cmd.scan_idx];
    if (starting_r[cmd.scan_idx] && (start_lim_r[cmd.scan_idx] != '0)) begin
      sa_mode_nxt  = CHK_START;
      sa_limit_nxt = start_lim_r[cmd.scan_idx];
    end else if (running_r[cmd.scan_idx] && (run_lim_r[cmd.scan_idx] != '0)) begin
      sa_mode_nxt  = CHK_RUN;
      sa_limit_nxt = run_lim_r[cmd.scan_idx];
    end else begin
      sa_mode_nxt  = CHK_NONE;
      sa_limit_nxt = run_lim_r[cmd.scan_idx];
    end
    // elapsed - limit > delay is the same as elapsed > limit + delay without wrap.
    sa_bound_nxt = {1'b0, sa_limit_nxt} + {1'b0, close_lim_r[cmd.scan_idx]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    sa_idx_r     <= cmd.scan_idx;
    sa_mode_r    <= sa_mode_nxt;
    sa_elapsed_r <= sa_elapsed_nxt;
    sa_limit_r   <= sa_limit_nxt;
    sa_bound_r   <= sa_bound_nxt;
    sa_close_r   <= close_ok_r[cmd.scan_idx];
  end

  always_comb begin
    timed_out  = (sa_elapsed_r > sa_limit_r);
    past_close = ({1'b0, sa_elapsed_r} > sa_bound_r);
    hit_err    = 1'b0;
    hit_cls    = 1'b0;
    clr_start  = 1'b0;
    clr_run    = 1'b0;
    case (sa_mode_r)
      CHK_START: begin
        if (timed_out) begin
          hit_err = 1'b1;
          if (past_close && sa_close_r) begin
            hit_cls   = 1'b1;
            clr_start = 1'b1;
          end
        end
      end
      CHK_RUN: begin
        if (timed_out) begin
          hit_err = 1'b1;
          if (past_close && sa_close_r) begin
            hit_cls = 1'b1;
            clr_run = 1'b1;
          end
        end else if (sa_close_r) begin
          // A healthy channel with close allowed fires its close action on every scan.
          hit_cls = 1'b1;
        end
      end
      default: begin
      end
    endcase
    sb_idx_ext = 32'(sa_idx_r);
    sb_in_mask = (sb_idx_ext < mltg_pkg::MASK_W);
    sb_bit     = sb_idx_ext[mltg_pkg::MASK_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= '0;
      starting_r <= '0;
      healthy_r  <= '0;
      close_ok_r <= '0;
      for (int i = 0; i < NCH; i++) begin
        last_r[i]      <= '0;
        start_lim_r[i] <= '0;
        run_lim_r[i]   <= '0;
        close_lim_r[i] <= '0;
      end
    end else begin
      if (cmd.apply) begin
        case (item_r.command)
          mltg_pkg::CMD_FEED: begin
            if (ch_ok && not_excl) begin
              running_r[ch_idx]  <= 1'b1;
              starting_r[ch_idx] <= 1'b0;
              healthy_r[ch_idx]  <= 1'b1;
              last_r[ch_idx]     <= item_r.time_now;
            end
          end
          mltg_pkg::CMD_INIT: begin
            if (ch_ok) begin
              running_r[ch_idx]   <= 1'b0;
              starting_r[ch_idx]  <= 1'b1;
              healthy_r[ch_idx]   <= 1'b0;
              last_r[ch_idx]      <= '0;
              start_lim_r[ch_idx] <= item_r.start_timeout;
              run_lim_r[ch_idx]   <= item_r.run_timeout;
              close_ok_r[ch_idx]  <= item_r.close_en;
              close_lim_r[ch_idx] <= item_r.close_delay;
            end
          end
          mltg_pkg::CMD_ENABLE_ALL: begin
            running_r <= '1;
          end
          default: begin
          end
        endcase
      end
      if (sa_valid_r) begin
        if (clr_start) starting_r[sa_idx_r] <= 1'b0;
        if (clr_run) running_r[sa_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_masks) begin
      err_r <= '0;
      cls_r <= '0;
    end else if (sa_valid_r && sb_in_mask) begin
      if (hit_err) err_r[sb_bit] <= 1'b1;
      if (hit_cls) cls_r[sb_bit] <= 1'b1;
    end
  end

  always_comb begin
    healthy_mask = '0;
    for (int i = 0; i < mltg_pkg::MASK_W; i++) begin
      if (i < NCH) healthy_mask[i] = healthy_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.error_mask   <= err_r;
      out_r.close_mask   <= cls_r;
      out_r.healthy_mask <= healthy_mask;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ hdl/multi_channel_link_timeout_guard.sv @@
`default_nettype none

// Per-channel heartbeat timeout monitor. Each input transfer carries one command
// (scan, feed, init or enable-all) and yields exactly one result transfer with the
// error, close and healthy masks. Items are handled one at a time: feed, init and
// enable-all pass from acceptance through dispatch to the response state, which
// loads the result once the output register is free; a scan is walked by the scan
// sequencer one channel per cycle through a two-stage read and compare datapath.
// A new item is accepted as soon as the block is back in idle, even while the
// previous result still waits in the output register. Register 0 at address 0
// holds the excluded channel (reset 8, none excluded).
module multi_channel_link_timeout_guard (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire mltg_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output mltg_pkg::out_item_t                   out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mltg_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [mltg_pkg::PDATA_W-1:0]     pwdata,
  output logic [mltg_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  logic [mltg_pkg::EXCL_W-1:0]    excl_r;
  logic [mltg_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;
  mltg_pkg::dp_cmd_t              cmd;
  mltg_pkg::dp_status_t           status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mltg_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_r <= mltg_pkg::EXCL_NONE;
    end else if (cfg_wr && (reg_idx == mltg_pkg::REG_EXCLUDED)) begin
      excl_r <= pwdata[mltg_pkg::EXCL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == mltg_pkg::REG_EXCLUDED) begin
      prdata = mltg_pkg::PDATA_W'(excl_r);
    end
  end

  mltg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mltg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data          (in_data),
    .excluded_channel (excl_r),
    .cmd              (cmd),
    .status           (status),
    .out_data         (out_data)
  );

endmodule

`default_nettype wire

@@ tb/sv/link_guard_checker.sv @@
`timescale 1ns / 100ps

module link_guard_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  mltg_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  mltg_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mltg_pkg::PADDR_W-1:0]   paddr,
  input  logic [mltg_pkg::PDATA_W-1:0]   pwdata,
  input  logic [mltg_pkg::PDATA_W-1:0]   prdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending
);

  logic [mltg_pkg::EXCL_W-1:0] excl;
  logic                        running   [mltg_pkg::NUM_CHANNELS];
  logic                        starting  [mltg_pkg::NUM_CHANNELS];
  logic                        healthy   [mltg_pkg::NUM_CHANNELS];
  logic                        close_ok  [mltg_pkg::NUM_CHANNELS];
  logic [mltg_pkg::TIME_W-1:0] last_feed [mltg_pkg::NUM_CHANNELS];
  logic [mltg_pkg::TIME_W-1:0] start_lim [mltg_pkg::NUM_CHANNELS];
  logic [mltg_pkg::TIME_W-1:0] run_lim   [mltg_pkg::NUM_CHANNELS];
  logic [mltg_pkg::TIME_W-1:0] close_lim [mltg_pkg::NUM_CHANNELS];

  mltg_pkg::out_item_t expected_masks[$];
  int                  mismatches = 0;

  task automatic clear_guard_state();
    int i;
    excl = mltg_pkg::EXCL_NONE;
    for (i = 0; i < mltg_pkg::NUM_CHANNELS; i++) begin
      running[i]   = 1'b0;
      starting[i]  = 1'b0;
      healthy[i]   = 1'b0;
      close_ok[i]  = 1'b0;
      last_feed[i] = '0;
      start_lim[i] = '0;
      run_lim[i]   = '0;
      close_lim[i] = '0;
    end
  endtask

  task automatic step_guard_state(input mltg_pkg::in_item_t it,
                                  output mltg_pkg::out_item_t masks);
    int i;
    logic [mltg_pkg::TIME_W-1:0] elapsed;
    masks = '0;
    case (it.command)
      mltg_pkg::CMD_SCAN: begin
        for (i = 0; i < mltg_pkg::NUM_CHANNELS; i++) begin
          elapsed = it.time_now - last_feed[i];
          if (starting[i] && start_lim[i] != '0) begin
            if (elapsed > start_lim[i]) begin
              if (i < mltg_pkg::MASK_W) masks.error_mask[i] = 1'b1;
              if (elapsed - start_lim[i] > close_lim[i] && close_ok[i]) begin
                starting[i] = 1'b0;
                if (i < mltg_pkg::MASK_W) masks.close_mask[i] = 1'b1;
              end
            end
          end else if (running[i] && run_lim[i] != '0) begin
            if (elapsed > run_lim[i]) begin
              if (i < mltg_pkg::MASK_W) masks.error_mask[i] = 1'b1;
              if (elapsed - run_lim[i] > close_lim[i] && close_ok[i]) begin
                running[i] = 1'b0;
                if (i < mltg_pkg::MASK_W) masks.close_mask[i] = 1'b1;
              end
            end else if (close_ok[i]) begin
              // A healthy channel with close enabled fires its close action every scan.
              if (i < mltg_pkg::MASK_W) masks.close_mask[i] = 1'b1;
            end
          end
        end
      end
      mltg_pkg::CMD_FEED: begin
        if ({1'b0, it.channel} != excl) begin
          running[it.channel]   = 1'b1;
          starting[it.channel]  = 1'b0;
          healthy[it.channel]   = 1'b1;
          last_feed[it.channel] = it.time_now;
        end
      end
      mltg_pkg::CMD_INIT: begin
        running[it.channel]   = 1'b0;
        starting[it.channel]  = 1'b1;
        healthy[it.channel]   = 1'b0;
        last_feed[it.channel] = '0;
        start_lim[it.channel] = it.start_timeout;
        run_lim[it.channel]   = it.run_timeout;
        close_ok[it.channel]  = it.close_en;
        close_lim[it.channel] = it.close_delay;
      end
      mltg_pkg::CMD_ENABLE_ALL: begin
        for (i = 0; i < mltg_pkg::NUM_CHANNELS; i++) running[i] = 1'b1;
      end
      default: ;
    endcase
    for (i = 0; i < mltg_pkg::NUM_CHANNELS; i++)
      if (healthy[i] && i < mltg_pkg::MASK_W) masks.healthy_mask[i] = 1'b1;
  endtask

  always @(posedge clk) begin : monitor
    mltg_pkg::out_item_t want;
    mltg_pkg::out_item_t predicted;
    if (!rst_n) begin
      clear_guard_state();
      expected_masks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_masks.size() == 0) begin
          $error("result transfer with no expected result: %h", out_data);
          mismatches++;
        end else begin
          want = expected_masks.pop_front();
          if (out_data.error_mask !== want.error_mask) begin
            $error("error_mask: expected %h, actual %h", want.error_mask, out_data.error_mask);
            mismatches++;
          end
          if (out_data.close_mask !== want.close_mask) begin
            $error("close_mask: expected %h, actual %h", want.close_mask, out_data.close_mask);
            mismatches++;
          end
          if (out_data.healthy_mask !== want.healthy_mask) begin
            $error("healthy_mask: expected %h, actual %h",
                   want.healthy_mask, out_data.healthy_mask);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        step_guard_state(in_data, predicted);
        expected_masks.push_back(predicted);
      end
      if (psel && penable && pready &&
          paddr[mltg_pkg::PADDR_W-1:2] == mltg_pkg::REG_EXCLUDED) begin
        if (pwrite) begin
          excl = pwdata[mltg_pkg::EXCL_W-1:0];
        end else if (prdata !== mltg_pkg::PDATA_W'(excl)) begin
          $error("excluded_channel: expected %h, actual %h",
                 mltg_pkg::PDATA_W'(excl), prdata);
          mismatches++;
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_masks.size();
  end

endmodule

@@ tb/sv/tb_multi_channel_link_timeout_guard.sv @@
`timescale 1ns / 100ps

module tb_multi_channel_link_timeout_guard;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 250;
  localparam int TW          = mltg_pkg::TIME_W;
  localparam logic [mltg_pkg::PADDR_W-1:0] ADDR_EXCLUDED = {mltg_pkg::REG_EXCLUDED, 2'b00};
  localparam logic [mltg_pkg::PADDR_W-1:0] ADDR_UNUSED   = 3'd4;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  mltg_pkg::in_item_t           in_data   = '0;
  logic                         out_ready = 1'b0;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [mltg_pkg::PADDR_W-1:0] paddr     = '0;
  logic [mltg_pkg::PDATA_W-1:0] pwdata    = '0;

  logic                         in_ready;
  logic                         out_valid;
  mltg_pkg::out_item_t          out_data;
  logic [mltg_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  int                           fail_count;
  int                           pending;
  int                           cycles    = 0;
  bit                           steady    = 1'b0;
  bit                           hold_req  = 1'b0;
  logic [TW-1:0]                tick      = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_channel_link_timeout_guard uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  link_guard_checker guard_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic mltg_pkg::in_item_t make_item(mltg_pkg::cmd_e_t cmd,
                                                   logic [mltg_pkg::CHAN_W-1:0] ch,
                                                   logic [TW-1:0] now,
                                                   logic [TW-1:0] st, logic [TW-1:0] rt,
                                                   logic ce, logic [TW-1:0] cd);
    mltg_pkg::in_item_t it;
    it.command       = cmd;
    it.channel       = ch;
    it.time_now      = now;
    it.start_timeout = st;
    it.run_timeout   = rt;
    it.close_en      = ce;
    it.close_delay   = cd;
    return it;
  endfunction

  // Mostly short limits so that timeouts and closes happen often, with the
  // disabled and near-wrap values mixed in.
  function automatic logic [TW-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return $urandom;
      2:       return {TW{1'b1}} - $urandom_range(0, 3);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic mltg_pkg::in_item_t random_item();
    mltg_pkg::in_item_t it;
    int pick;
    tick = tick + $urandom_range(0, 40);
    it.channel       = mltg_pkg::CHAN_W'($urandom_range(0, 7));
    it.time_now      = ($urandom_range(0, 49) == 0) ? $urandom : tick;
    it.start_timeout = pick_limit();
    it.run_timeout   = pick_limit();
    it.close_en      = 1'($urandom_range(0, 1));
    it.close_delay   = pick_limit();
    pick = $urandom_range(0, 99);
    if (pick < 40)      it.command = mltg_pkg::CMD_SCAN;
    else if (pick < 75) it.command = mltg_pkg::CMD_FEED;
    else if (pick < 92) it.command = mltg_pkg::CMD_INIT;
    else                it.command = mltg_pkg::CMD_ENABLE_ALL;
    return it;
  endfunction

  task automatic send_item(input mltg_pkg::in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_access(input logic wr, input logic [mltg_pkg::PADDR_W-1:0] addr,
                            input logic [mltg_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int p;
    int n;
    logic [mltg_pkg::EXCL_W-1:0] excl_val;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, ADDR_EXCLUDED, '0);

    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd0, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_ENABLE_ALL, 3'd0, 32'd0, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd5, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_INIT, 3'd0, 32'd0, 32'd100, 32'd50, 1'b1, 32'd20));
    send_item(make_item(mltg_pkg::CMD_INIT, 3'd7, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0,
                        32'hFFFF_FFFF));
    // Start phase: inside the limit, past it, then past the close delay.
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd50, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd110, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd200, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_FEED, 3'd0, 32'd1000, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd1040, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd1060, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd1100, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd1200, '0, '0, 1'b0, '0));
    // Elapsed time across the 32-bit wrap.
    send_item(make_item(mltg_pkg::CMD_FEED, 3'd7, 32'hFFFF_FFF0, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_ENABLE_ALL, 3'd7, 32'hFFFF_FFFF, '0, '0, 1'b1, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd10, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_INIT, 3'd5, 32'd0, 32'd1, 32'd0, 1'b1, 32'd0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd2, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_INIT, 3'd3, {TW{1'b1}}, {TW{1'b1}}, {TW{1'b1}},
                        1'b1, {TW{1'b1}}));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd7, {TW{1'b1}}, {TW{1'b1}}, {TW{1'b1}},
                        1'b1, {TW{1'b1}}));
    drain_results();

    // Feeds to the excluded channel are dropped, inits to it are not.
    cfg_access(1'b1, ADDR_EXCLUDED, mltg_pkg::PDATA_W'(4'd2));
    cfg_access(1'b0, ADDR_EXCLUDED, '0);
    send_item(make_item(mltg_pkg::CMD_FEED, 3'd2, 32'd300, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_FEED, 3'd3, 32'd300, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_SCAN, 3'd0, 32'd400, '0, '0, 1'b0, '0));
    drain_results();
    cfg_access(1'b1, ADDR_UNUSED, '0);
    cfg_access(1'b0, ADDR_EXCLUDED, '0);
    send_item(make_item(mltg_pkg::CMD_FEED, 3'd2, 32'd500, '0, '0, 1'b0, '0));
    send_item(make_item(mltg_pkg::CMD_INIT, 3'd2, 32'd0, '0, '0, 1'b0, '0));
    drain_results();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       excl_val = mltg_pkg::EXCL_NONE;
        1:       excl_val = 4'd0;
        2:       excl_val = 4'd7;
        3:       excl_val = 4'd15;
        4:       excl_val = 4'd3;
        default: excl_val = mltg_pkg::EXCL_W'($urandom_range(0, 15));
      endcase
      cfg_access(1'b1, ADDR_EXCLUDED, mltg_pkg::PDATA_W'(excl_val));
      cfg_access(1'b0, ADDR_EXCLUDED, '0);
      tick   = (p == 4) ? 32'hFFFF_F000 : $urandom;
      steady = (p == 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // The sink stalls for a long stretch while the stimulus keeps offering items.
        if (p == 2 && n == 100) hold_req = 1'b1;
        if (p == 3 && n == 125) drain_results();
        send_item(random_item());
      end
      drain_results();
    end

    steady = 1'b0;
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
